FILE: rtl/core/symbol_index_table_defines.svh
// Assertion macros for the symbol index table checker.
`ifndef SYMBOL_INDEX_TABLE_DEFINES_SVH
`define SYMBOL_INDEX_TABLE_DEFINES_SVH

// Antecedent in one cycle, consequent in the next.
`define SIT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

// Antecedent and consequent in the same cycle.
`define SIT_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

`endif

FILE: rtl/core/sit_pkg.sv
// Shared constants and types of the symbol index table.
`default_nettype none

package sit_pkg;

	localparam int SLOTS = 128;
	// counter reaches SLOTS when a search runs off the last cell
	localparam int CNT_W = $clog2(SLOTS + 1);

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [2:0] ST_FOUND     = 3'd0;
	localparam logic [2:0] ST_INSERTED  = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_CLEARED   = 3'd4;

	// search token walking down the cell chain
	typedef struct packed {
		logic       valid;
		logic [1:0] op;
		logic [7:0] sym;
	} tok_t;

	// per-cell outcome while it holds the token
	typedef struct packed {
		logic hit;
		logic free;
	} rsp_t;

	// chain outcome seen by the controller
	typedef struct packed {
		logic hit;
		logic free;
		logic tail;
	} srch_t;

endpackage

`default_nettype wire

FILE: rtl/core/sit_cell.sv
// One table slot: stored symbol, occupied flag and the token stage to the next slot.
`default_nettype none

module sit_cell import sit_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  logic clr,
	input  tok_t tok_in,
	output tok_t tok_out,
	output rsp_t rsp
);

	logic [7:0] entry_q;
	logic       occ_q;
	tok_t       tok_q;
	logic       match;
	logic       wr_en;

	assign match = tok_in.valid && occ_q && (tok_in.sym == entry_q) && (tok_in.sym != 8'd0);
	assign rsp.hit  = match;
	assign rsp.free = tok_in.valid && !occ_q;

	// first free slot takes a new nonzero symbol
	assign wr_en = rsp.free && (tok_in.op == OP_INSERT) && (tok_in.sym != 8'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (clr) begin
			occ_q <= 1'b0;
		end else if (wr_en) begin
			occ_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q <= tok_in.sym;
		end
	end

	// token moves on only past an occupied, non-matching slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_in.valid && occ_q && !match;
			tok_q.op    <= tok_in.op;
			tok_q.sym   <= tok_in.sym;
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

FILE: rtl/core/sit_ctrl.sv
// Handshake, token launch, slot counter and result register of the symbol index table.
`default_nettype none

module sit_ctrl import sit_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [7:0]  symbol,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  slot_index,
	output logic [2:0]  status,
	output tok_t        launch,
	output logic        clr,
	input  srch_t       srch
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SEARCH = 3'b010,
		S_HOLD   = 3'b100
	} state_t;

	state_t             state_q, state_d;
	tok_t               launch_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W+6:0]   cnt_ext;
	logic [6:0]         cnt_slot;
	logic               accept;
	logic               is_search;
	logic               out_ok;
	logic               res_valid;
	logic [6:0]         res_slot;
	logic [2:0]         res_status;
	logic [6:0]         pend_slot_q;
	logic [2:0]         pend_status_q;
	logic               out_valid_q;
	logic [6:0]         slot_q;
	logic [2:0]         status_q;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && (state_q == S_IDLE);
	assign is_search = (operation == OP_LOOKUP) || (operation == OP_INSERT);
	assign out_ok    = !out_valid_q || !out_stall;
	assign clr       = accept && (operation == OP_CLEAR);

	// slot number keeps its low 7 bits
	assign cnt_ext  = {7'd0, cnt_q};
	assign cnt_slot = cnt_ext[6:0];

	always_comb begin
		res_valid  = 1'b0;
		res_slot   = 7'd0;
		res_status = ST_NOT_FOUND;
		case (state_q)
			S_IDLE: begin
				if (accept && !is_search) begin
					res_valid  = 1'b1;
					res_status = (operation == OP_CLEAR) ? ST_CLEARED : ST_NOT_FOUND;
				end
			end
			S_SEARCH: begin
				if (srch.hit) begin
					res_valid  = 1'b1;
					res_slot   = cnt_slot;
					res_status = ST_FOUND;
				end else if (srch.free) begin
					res_valid = 1'b1;
					if (launch_q.op == OP_INSERT) begin
						res_slot   = cnt_slot;
						res_status = (launch_q.sym == 8'd0) ? ST_FOUND : ST_INSERTED;
					end
				end else if (srch.tail) begin
					res_valid  = 1'b1;
					res_status = (launch_q.op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
				end
			end
			S_HOLD: begin
				res_valid  = 1'b1;
				res_slot   = pend_slot_q;
				res_status = pend_status_q;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && is_search) begin
					state_d = S_SEARCH;
				end else if (res_valid && !out_ok) begin
					state_d = S_HOLD;
				end
			end
			S_SEARCH: begin
				if (res_valid) begin
					state_d = out_ok ? S_IDLE : S_HOLD;
				end
			end
			S_HOLD: begin
				if (out_ok) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			launch_q    <= '0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (out_ok) begin
				out_valid_q <= res_valid;
			end
			launch_q.valid <= accept && is_search;
			if (accept) begin
				launch_q.op  <= operation;
				launch_q.sym <= symbol;
				cnt_q        <= '0;
			end else if (state_q == S_SEARCH) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_ok) begin
			slot_q   <= res_slot;
			status_q <= res_status;
		end
		if (res_valid && !out_ok) begin
			pend_slot_q   <= res_slot;
			pend_status_q <= res_status;
		end
	end

	assign launch     = launch_q;
	assign out_valid  = out_valid_q;
	assign slot_index = slot_q;
	assign status     = status_q;

endmodule

`default_nettype wire

FILE: rtl/core/symbol_index_table.sv
// Symbol index table top level: controller and the chain of slot cells.
//
// Input channel (in_valid / in_stall) carries operation and symbol; output
// channel (out_valid / out_stall) carries slot_index and status, one result
// per item, in order.
// Lookup and insert launch a search token that walks the slot cells, one
// cell per cycle, and stops at the first matching slot or the first free
// slot, whose index is the fill count on a miss; with no match in a full
// table it runs off the last cell. No new item is taken while a search
// runs; the next one can be taken in the cycle after the result is
// registered, so the item rate is set by the walk through the cell chain.
// Clear and the unused code give their result one cycle after acceptance
// and cost one cycle per item.
// A stalled receiver holds the output register; a finished result then waits
// in a holding register and no new item is taken until it moves on.
// Reset clears all occupied flags at once, so the table is empty right away.
`default_nettype none

module symbol_index_table import sit_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] operation,
	input  logic [7:0] symbol,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] slot_index,
	output logic [2:0] status
);

	tok_t             chain [SLOTS+1];
	rsp_t             rsp   [SLOTS];
	logic [SLOTS-1:0] hit_v;
	logic [SLOTS-1:0] free_v;
	logic             clr;
	srch_t            srch;

	sit_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.symbol     (symbol),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.slot_index (slot_index),
		.status     (status),
		.launch     (chain[0]),
		.clr        (clr),
		.srch       (srch)
	);

	for (genvar k = 0; k < SLOTS; k++) begin : g_cell
		sit_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.clr     (clr),
			.tok_in  (chain[k]),
			.tok_out (chain[k+1]),
			.rsp     (rsp[k])
		);
		assign hit_v[k]  = rsp[k].hit;
		assign free_v[k] = rsp[k].free;
	end

	// only one cell holds the token at a time
	assign srch.hit  = |hit_v;
	assign srch.free = |free_v;
	assign srch.tail = chain[SLOTS].valid;

endmodule

`default_nettype wire

FILE: rtl/core/sit_checker.sv
// Port-level checker of the symbol index table and its bind.
`default_nettype none
`include "symbol_index_table_defines.svh"

module sit_checker import sit_pkg::*; (
	input wire        clk,
	input wire        arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [1:0] operation,
	input logic       out_valid,
	input logic       out_stall,
	input logic [6:0] slot_index,
	input logic [2:0] status
);

	// a clear with a free output shows up as the next result
	`SIT_ASSERT_NEXT(a_clear_result, in_valid && !in_stall && operation == OP_CLEAR && (!out_valid || !out_stall), out_valid && status == ST_CLEARED && slot_index == 7'd0)

	// an accepted search closes the input
	`SIT_ASSERT_NEXT(a_search_busy, in_valid && !in_stall && (operation == OP_LOOKUP || operation == OP_INSERT), in_stall)

	`SIT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(slot_index) && $stable(status))

	// no slot number goes with a miss, full or clear
	`SIT_ASSERT_SAME(a_zero_slot, out_valid && (status == ST_NOT_FOUND || status == ST_FULL || status == ST_CLEARED), slot_index == 7'd0)

endmodule

bind symbol_index_table sit_checker u_sit_checker (.*);

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for the symbol index table: directed items, then random lookup, insert and clear traffic.
`timescale 1ns / 100ps

module tb_top;
	import sit_pkg::*;

	// the fourth operation code does nothing but still gives one result
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int NUM_ITEMS = 1050;
	localparam int CALM_TAIL = 150;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] sym;
	} table_op_t;

	typedef struct packed {
		logic [6:0] slot_index;
		logic [2:0] status;
	} slot_reply_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] operation = OP_LOOKUP;
	logic [7:0] symbol = 8'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [6:0] slot_index;
	logic [2:0] status;

	symbol_index_table dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.symbol     (symbol),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.slot_index (slot_index),
		.status     (status)
	);

	table_op_t   ops_to_send[$];
	slot_reply_t replies_due[$];

	// predicted table contents
	logic [7:0]  stored_syms [SLOTS];
	int unsigned stored_count = 0;

	// what the stimulus generator believes is stored, used to aim lookups
	bit          gen_present [256];
	logic [7:0]  gen_known[$];
	int          gen_fill = 0;

	int total_items = NUM_ITEMS;
	int sent_count = 0;
	int replies_seen = 0;
	int mismatches = 0;
	int gap_left = 0;
	int stall_left = 0;
	logic hold_off = 1'b0;
	table_op_t   next_op;
	slot_reply_t want;
	logic [6:0]  pred_slot;
	logic [2:0]  pred_status;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void apply_table_op(input logic [1:0] op, input logic [7:0] sym,
		output logic [6:0] slot, output logic [2:0] st);
		int hit;
		int k;
		hit = -1;
		slot = 7'd0;
		st = ST_NOT_FOUND;
		// zero never matches anything
		if (sym != 8'd0) begin
			k = 0;
			while (hit < 0 && k < int'(stored_count)) begin
				if (stored_syms[k] == sym)
					hit = k;
				k++;
			end
		end
		case (op)
			OP_LOOKUP: begin
				if (hit >= 0) begin
					slot = hit[6:0];
					st = ST_FOUND;
				end
			end
			OP_INSERT: begin
				if (hit >= 0) begin
					slot = hit[6:0];
					st = ST_FOUND;
				end else if (stored_count >= SLOTS) begin
					st = ST_FULL;
				end else if (sym == 8'd0) begin
					// reports the first free slot, stores nothing
					slot = stored_count[6:0];
					st = ST_FOUND;
				end else begin
					stored_syms[stored_count] = sym;
					slot = stored_count[6:0];
					stored_count++;
					st = ST_INSERTED;
				end
			end
			OP_CLEAR: begin
				stored_count = 0;
				st = ST_CLEARED;
			end
			default: ;
		endcase
	endfunction

	task automatic add_op(input logic [1:0] op, input logic [7:0] sym);
		table_op_t item;
		item.op = op;
		item.sym = sym;
		ops_to_send.push_back(item);
		if (op == OP_CLEAR) begin
			foreach (gen_present[i])
				gen_present[i] = 1'b0;
			gen_known.delete();
			gen_fill = 0;
		end else if (op == OP_INSERT && sym != 8'd0 && !gen_present[sym] && gen_fill < SLOTS) begin
			gen_present[sym] = 1'b1;
			gen_known.push_back(sym);
			gen_fill++;
		end
	endtask

	function automatic logic [7:0] pick_known();
		if (gen_known.size() == 0)
			return 8'($urandom_range(1, 255));
		return gen_known[$urandom_range(0, gen_known.size() - 1)];
	endfunction

	// driver: predicts each accepted item, then offers the next one
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				apply_table_op(operation, symbol, pred_slot, pred_status);
				replies_due.push_back('{slot_index: pred_slot, status: pred_status});
				sent_count++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (ops_to_send.size() > 0) begin
					next_op = ops_to_send.pop_front();
					in_valid <= 1'b1;
					operation <= next_op.op;
					symbol <= next_op.sym;
					if (sent_count + CALM_TAIL < total_items && $urandom_range(0, 4) == 0)
						gap_left <= $urandom_range(1, 7);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks results in order and drives the output stall
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					$error("unexpected result: slot_index %0d status %0d", slot_index, status);
					mismatches++;
				end else begin
					want = replies_due.pop_front();
					if (slot_index !== want.slot_index) begin
						$error("slot_index: expected %0d, got %0d", want.slot_index, slot_index);
						mismatches++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						mismatches++;
					end
				end
				replies_seen++;
			end
			if (hold_off) begin
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else if (replies_seen + CALM_TAIL < total_items && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				stall_left <= $urandom_range(0, 6);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// long receiver hold-off so the block backs up into its input
	initial begin
		wait (sent_count >= 300);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#10_000_000;
		$display("tb_top failed");
		$finish;
	end

	initial begin
		int seg_kind;
		int fills_done;
		fills_done = 0;
		foreach (gen_present[i])
			gen_present[i] = 1'b0;

		// directed: empty table, zero symbol, extremes, unused code, clear
		add_op(OP_LOOKUP, 8'h00);
		add_op(OP_INSERT, 8'h00);
		add_op(OP_LOOKUP, 8'hFF);
		add_op(OP_INSERT, 8'hFF);
		add_op(OP_INSERT, 8'h01);
		add_op(OP_INSERT, 8'hFF);
		add_op(OP_LOOKUP, 8'h01);
		add_op(OP_LOOKUP, 8'h00);
		add_op(OP_INSERT, 8'h00);
		add_op(OP_INSERT, 8'h80);
		add_op(OP_LOOKUP, 8'h80);
		add_op(OP_UNUSED, 8'hAA);
		add_op(OP_UNUSED, 8'h55);
		add_op(OP_LOOKUP, 8'hAA);
		add_op(OP_CLEAR, 8'hFF);
		add_op(OP_LOOKUP, 8'hFF);
		add_op(OP_INSERT, 8'h7F);
		add_op(OP_LOOKUP, 8'h7F);
		add_op(OP_CLEAR, 8'h00);

		// random segments; the first one fills the table completely
		seg_kind = 0;
		while (ops_to_send.size() < NUM_ITEMS) begin
			// a fill segment is long, so it only starts well before the end
			if (seg_kind == 0 && fills_done < 5 && ops_to_send.size() + 250 < NUM_ITEMS) begin
				fills_done++;
				add_op(OP_CLEAR, 8'($urandom));
				while (gen_fill < SLOTS)
					add_op(OP_INSERT, 8'($urandom_range(1, 255)));
				// probes on a full table: inserts and lookups of random, stored and zero symbols
				repeat ($urandom_range(8, 16)) begin
					case ($urandom_range(0, 4))
						0: add_op(OP_INSERT, 8'($urandom_range(1, 255)));
						1: add_op(OP_INSERT, pick_known());
						2: add_op(OP_INSERT, 8'h00);
						3: add_op(OP_LOOKUP, pick_known());
						default: add_op(OP_LOOKUP, 8'($urandom_range(0, 255)));
					endcase
				end
			end else if (seg_kind <= 7) begin
				if ($urandom_range(0, 1) == 0)
					add_op(OP_CLEAR, 8'($urandom));
				repeat ($urandom_range(1, 24))
					add_op(OP_INSERT, 8'($urandom_range(1, 255)));
				repeat ($urandom_range(5, 25)) begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3: add_op(OP_LOOKUP, pick_known());
						4: add_op(OP_LOOKUP, 8'($urandom_range(1, 255)));
						5, 6: add_op(OP_INSERT, 8'($urandom_range(1, 255)));
						7: add_op(OP_INSERT, pick_known());
						8: add_op(OP_INSERT, 8'h00);
						default: add_op(OP_LOOKUP, 8'h00);
					endcase
				end
			end else begin
				// noise: any code, any symbol
				repeat ($urandom_range(3, 12))
					add_op(2'($urandom_range(0, 3)),
						$urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom_range(0, 255)));
			end
			seg_kind = $urandom_range(0, 9);
		end
		total_items = ops_to_send.size();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!(sent_count == total_items && replies_due.size() == 0))
			@(posedge clk);
		repeat (SLOTS + 8) @(posedge clk);

		if (mismatches == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
